/* hdl/pirrt_pkg.sv */
package pirrt_pkg;

  // angle and trig precision
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int CORDIC_STEPS   = 30;

  // field widths
  localparam int COORD_W = 32;
  localparam int ANG_W   = 16;
  localparam int EXT_W   = 31;
  localparam int SCALE_W = 16;

  // internal widths
  localparam int OFF_W  = COORD_W + 1;
  localparam int BND_W  = EXT_W + 1 + SCALE_W;
  localparam int CX_W   = 33;
  localparam int Z_W    = 32;
  localparam int CS_W   = TRIG_FRAC_BITS + 2;
  localparam int CS_SH  = 30 - TRIG_FRAC_BITS;
  localparam int PROD_W = CS_W + OFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SH_W   = SUM_W - TRIG_FRAC_BITS;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // atan(2^-i) in 2^32 units per turn
  localparam logic [Z_W-1:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [BND_W-1:0] bnd_x;
    logic signed [BND_W-1:0] bnd_y;
  } bnd_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
    bnd_t                    bnd;
  } side_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } rot_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
  } res_t;

endpackage

/* hdl/pirrt_front.sv */
module pirrt_front import pirrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] rect_x_i,
  input  logic signed [COORD_W-1:0] rect_y_i,
  input  logic        [ANG_W-1:0]   rect_angle_i,
  input  logic        [EXT_W-1:0]   half_width_i,
  input  logic        [EXT_W-1:0]   half_height_i,
  input  logic signed [SCALE_W-1:0] scale_x_i,
  input  logic signed [SCALE_W-1:0] scale_y_i,
  output logic                      valid_o,
  output rot_t                      rot_o,
  output side_t                     side_o
);

  localparam logic signed [Z_W:0] QuarterTurn = 33'sh040000000;
  localparam logic signed [Z_W:0] HalfTurn    = 33'sh080000000;

  logic [31:0]             a32;
  logic signed [Z_W:0]     z_ext;
  logic signed [Z_W:0]     z_fold;
  logic                    flip;
  rot_t                    rot_d, rot_q;
  side_t                   side_d, side_q;
  logic                    valid_q;

  always_comb begin
    a32   = (32'(rect_angle_i) & ANGLE_MASK) << (32 - ANGLE_BITS);
    z_ext = (Z_W+1)'($signed(a32));
    // fold into [-1/4, 1/4] turn, negate the result afterwards
    if (z_ext > QuarterTurn) begin
      z_fold = z_ext - HalfTurn;
      flip   = 1'b1;
    end else if (z_ext < -QuarterTurn) begin
      z_fold = z_ext + HalfTurn;
      flip   = 1'b1;
    end else begin
      z_fold = z_ext;
      flip   = 1'b0;
    end
    rot_d.x    = CORDIC_GAIN_Q30;
    rot_d.y    = '0;
    rot_d.z    = z_fold[Z_W-1:0];
    rot_d.flip = flip;

    side_d.dx        = OFF_W'(point_x_i) - OFF_W'(rect_x_i);
    side_d.dy        = OFF_W'(point_y_i) - OFF_W'(rect_y_i);
    side_d.bnd.bnd_x = BND_W'($signed({1'b0, half_width_i})) * BND_W'(scale_x_i);
    side_d.bnd.bnd_y = BND_W'($signed({1'b0, half_height_i})) * BND_W'(scale_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign side_o  = side_q;

endmodule

/* hdl/pirrt_cordic.sv */
module pirrt_cordic import pirrt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  rot_t                   rot_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o,
  output side_t                  side_o
);

  localparam logic signed [CX_W-1:0] CsRnd = CX_W'(64'd1 << (CS_SH - 1));

  rot_t                    nxt  [CORDIC_STEPS];
  rot_t                    st_q [CORDIC_STEPS];
  side_t                   sd_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] v_q;

  logic signed [CX_W-1:0]  xf, yf, xr, yr;
  logic signed [CS_W-1:0]  cos_d, sin_d, cos_q, sin_q;
  side_t                   side_q;
  logic                    valid_q;

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    rot_t prev;
    if (i == 0) begin : g_first
      assign prev = rot_i;
    end else begin : g_rest
      assign prev = st_q[i-1];
    end
    always_comb begin
      nxt[i].flip = prev.flip;
      if (prev.z >= 0) begin
        nxt[i].x = prev.x - (prev.y >>> i);
        nxt[i].y = prev.y + (prev.x >>> i);
        nxt[i].z = prev.z - $signed(ATAN_TURN32[i]);
      end else begin
        nxt[i].x = prev.x + (prev.y >>> i);
        nxt[i].y = prev.y - (prev.x >>> i);
        nxt[i].z = prev.z + $signed(ATAN_TURN32[i]);
      end
    end
  end

  always_comb begin
    xf    = st_q[CORDIC_STEPS-1].flip ? -st_q[CORDIC_STEPS-1].x : st_q[CORDIC_STEPS-1].x;
    yf    = st_q[CORDIC_STEPS-1].flip ? -st_q[CORDIC_STEPS-1].y : st_q[CORDIC_STEPS-1].y;
    xr    = xf + CsRnd;
    yr    = yf + CsRnd;
    cos_d = CS_W'(xr >>> CS_SH);
    sin_d = CS_W'(yr >>> CS_SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[CORDIC_STEPS-2:0], valid_i};
      valid_q <= v_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= side_i;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        st_q[k] <= nxt[k];
      end
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      cos_q  <= cos_d;
      sin_q  <= sin_d;
      side_q <= sd_q[CORDIC_STEPS-1];
    end
  end

  assign valid_o = valid_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_q;

endmodule

/* hdl/pirrt_rotate.sv */
module pirrt_rotate import pirrt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [CS_W-1:0] cos_i,
  input  logic signed [CS_W-1:0] sin_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  output res_t                   res_o
);

  localparam logic signed [SUM_W-1:0]   LocRnd = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));
  localparam logic signed [SH_W-1:0]    SatMax = SH_W'(64'sh7FFFFFFF);
  localparam logic signed [SH_W-1:0]    SatMin = SH_W'(-64'sh80000000);
  localparam logic signed [COORD_W-1:0] OutMax = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] OutMin = 32'sh80000000;

  logic [3:0] v_q;

  // products
  logic signed [PROD_W-1:0] cdx_q, sdy_q, cdy_q, sdx_q;
  bnd_t                     b1_q;
  // sums
  logic signed [SUM_W-1:0]  sx_d, sy_d, sx_q, sy_q;
  bnd_t                     b2_q;
  // rounded and saturated
  logic signed [SH_W-1:0]   rx, ry;
  logic signed [COORD_W-1:0] lx_d, ly_d, lx_q, ly_q;
  bnd_t                     b3_q;
  // bound check
  logic signed [BND_W-1:0]  ex, ey, ax, ay;
  logic                     hit;
  res_t                     res_d, res_q;

  always_comb begin
    sx_d = SUM_W'(cdx_q) + SUM_W'(sdy_q);
    sy_d = SUM_W'(cdy_q) - SUM_W'(sdx_q);

    rx = SH_W'((sx_q + LocRnd) >>> TRIG_FRAC_BITS);
    ry = SH_W'((sy_q + LocRnd) >>> TRIG_FRAC_BITS);
    if (rx > SatMax)      lx_d = OutMax;
    else if (rx < SatMin) lx_d = OutMin;
    else                  lx_d = rx[COORD_W-1:0];
    if (ry > SatMax)      ly_d = OutMax;
    else if (ry < SatMin) ly_d = OutMin;
    else                  ly_d = ry[COORD_W-1:0];

    // |local| << 8 against the Q40.8 bound
    ex  = BND_W'(lx_q);
    ey  = BND_W'(ly_q);
    ax  = ((ex < 0) ? -ex : ex) <<< 8;
    ay  = ((ey < 0) ? -ey : ey) <<< 8;
    hit = (ax <= b3_q.bnd_x) && (ay <= b3_q.bnd_y);
    res_d.hit = hit;
    res_d.lx  = hit ? lx_q : '0;
    res_d.ly  = hit ? ly_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cdx_q <= PROD_W'(cos_i) * PROD_W'(side_i.dx);
      sdy_q <= PROD_W'(sin_i) * PROD_W'(side_i.dy);
      cdy_q <= PROD_W'(cos_i) * PROD_W'(side_i.dy);
      sdx_q <= PROD_W'(sin_i) * PROD_W'(side_i.dx);
      b1_q  <= side_i.bnd;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      b2_q  <= b1_q;
      lx_q  <= lx_d;
      ly_q  <= ly_d;
      b3_q  <= b2_q;
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[3];
  assign res_o   = res_q;

endmodule

/* hdl/pirrt_outbuf.sv */
module pirrt_outbuf import pirrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  res_t                      res_i,
  output logic                      en_o,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic                      hit_o,
  output logic signed [COORD_W-1:0] local_x_o,
  output logic signed [COORD_W-1:0] local_y_o
);

  logic out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic out_ld, skid_ld;
  res_t out_d, out_q;

  // pipeline moves only while the skid slot is free
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = res_i;
    out_ld   = 1'b0;
    skid_ld  = 1'b0;
    if (skid_v_q) begin
      if (!stall_i) begin
        out_v_d  = 1'b1;
        out_d    = 'x;
        out_ld   = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (!out_v_q || !stall_i) begin
      out_v_d = valid_i;
      out_ld  = 1'b1;
    end else if (valid_i) begin
      skid_v_d = 1'b1;
      skid_ld  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  res_t skid_q;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= skid_v_q ? skid_q : out_d;
    end
    if (skid_ld) begin
      skid_q <= res_i;
    end
  end

  assign en_o      = !skid_v_q;
  assign valid_o   = out_v_q;
  assign hit_o     = out_q.hit;
  assign local_x_o = out_q.lx;
  assign local_y_o = out_q.ly;

endmodule

/* hdl/point_in_rotated_rect_test_top.sv */
// Point in rotated rectangle test.
// Input channel: valid_i / stall_o with one request per accepted cycle
// (valid_i high, stall_o low): point, rectangle centre, angle, half
// extents and scales. Output channel: valid_o / stall_i carries hit and
// the point in the rectangle frame (zero on a miss).
// When nothing stalls, a request passes one offset/bound stage, 30 CORDIC
// stages, one trig rounding stage, four rotate/round/compare stages and
// the output register on its way from the accepting edge to valid_o.
// Throughput is one request per cycle while stall_o is low; the CORDIC
// pipeline and the four multipliers take a new request every such cycle.
// Reset clears all valid bits; no request is in flight afterwards.
// When the receiver stalls, the result waiting in the output register holds
// and one more result lands in a skid register; stall_o then rises and the
// whole pipeline freezes until the skid register drains. Nothing is lost or
// repeated; bubbles in the pipeline are not squeezed out while frozen.
module point_in_rotated_rect_test_top import pirrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] rect_x_i,
  input  logic signed [COORD_W-1:0] rect_y_i,
  input  logic        [ANG_W-1:0]   rect_angle_i,
  input  logic        [EXT_W-1:0]   half_width_i,
  input  logic        [EXT_W-1:0]   half_height_i,
  input  logic signed [SCALE_W-1:0] scale_x_i,
  input  logic signed [SCALE_W-1:0] scale_y_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic                      hit_o,
  output logic signed [COORD_W-1:0] local_x_o,
  output logic signed [COORD_W-1:0] local_y_o
);

  logic                   en;
  logic                   f_valid, c_valid, r_valid;
  rot_t                   f_rot;
  side_t                  f_side, c_side;
  logic signed [CS_W-1:0] c_cos, c_sin;
  res_t                   r_res;

  assign stall_o = !en;

  pirrt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (valid_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_angle_i  (rect_angle_i),
    .half_width_i  (half_width_i),
    .half_height_i (half_height_i),
    .scale_x_i     (scale_x_i),
    .scale_y_i     (scale_y_i),
    .valid_o       (f_valid),
    .rot_o         (f_rot),
    .side_o        (f_side)
  );

  pirrt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rot_i   (f_rot),
    .side_i  (f_side),
    .valid_o (c_valid),
    .cos_o   (c_cos),
    .sin_o   (c_sin),
    .side_o  (c_side)
  );

  pirrt_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .cos_i   (c_cos),
    .sin_i   (c_sin),
    .side_i  (c_side),
    .valid_o (r_valid),
    .res_o   (r_res)
  );

  pirrt_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (r_valid),
    .res_i     (r_res),
    .en_o      (en),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .hit_o     (hit_o),
    .local_x_o (local_x_o),
    .local_y_o (local_y_o)
  );

endmodule
